// ===== hdl/cifr_pkg.sv =====
// ----------------------------------------------------------------------------
// cifr_pkg
// Shared types and constants for the camera image frame receiver.
// ----------------------------------------------------------------------------
package cifr_pkg;

  // Largest image length that the camera may announce, in bytes
  localparam logic [18:0] MAX_IMAGE_BYTES = 19'd262144;

  // Register reset values
  localparam logic [15:0] SILENCE_TIMEOUT_RST = 16'd15000;
  localparam logic [15:0] ACK_CHUNK_RST       = 16'd1024;

  // Camera link characters
  localparam logic [7:0] CH_START   = 8'h53;  // 'S'
  localparam logic [7:0] CH_END     = 8'h45;  // 'E'
  localparam logic [7:0] CH_ERROR   = 8'h58;  // 'X'
  localparam logic [7:0] CH_ACK     = 8'h41;  // 'A'
  localparam logic [7:0] CH_CAPTURE = 8'h43;  // 'C'

  // Configuration register indexes
  localparam logic REG_SILENCE_TIMEOUT = 1'b0;
  localparam logic REG_ACK_CHUNK       = 1'b1;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_CAPTURE = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WAIT  = 2'd1,
    MODE_READY = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_SIZE  = 2'd1,
    PH_DATA  = 2'd2,
    PH_END   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_DATA     = 3'd1,
    ST_COMPLETE = 3'd2,
    ST_CAM_ERR  = 3'd3,
    ST_TOO_BIG  = 3'd4,
    ST_TIMEOUT  = 3'd5
  } status_t;

  typedef struct packed {
    logic [15:0] silence_timeout_ms;
    logic [15:0] ack_chunk_bytes;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [17:0] write_offset;
    logic [7:0]  write_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [18:0] image_size;
    logic [18:0] bytes_received;
    logic [1:0]  camera_mode;
  } res_t;

endpackage

// ===== hdl/cifr_cfg.sv =====
// ----------------------------------------------------------------------------
// cifr_cfg
// APB register file: silence timeout and acknowledge chunk size.
// ----------------------------------------------------------------------------
module cifr_cfg
  import cifr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.silence_timeout_ms <= SILENCE_TIMEOUT_RST;
      cfg.ack_chunk_bytes    <= ACK_CHUNK_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_SILENCE_TIMEOUT) begin
        cfg.silence_timeout_ms <= pwdata[15:0];
      end else begin
        cfg.ack_chunk_bytes <= pwdata[15:0];
      end
    end
  end

  // Read back
  always_comb begin
    if (paddr[2] == REG_SILENCE_TIMEOUT) begin
      prdata = {16'd0, cfg.silence_timeout_ms};
    end else begin
      prdata = {16'd0, cfg.ack_chunk_bytes};
    end
  end

endmodule

// ===== hdl/cifr_core.sv =====
// ----------------------------------------------------------------------------
// cifr_core
// Frame parser state and per-item next-state logic. Produces one result per
// item; state advances when the item is handed to the result register.
// ----------------------------------------------------------------------------
module cifr_core
  import cifr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  op_t        op,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output res_t       res
);

  mode_t       mode, mode_next;
  phase_t      phase, phase_next;
  logic [1:0]  len_seen, len_seen_next;
  logic [18:0] len_accum, len_accum_next;   // low 19 bits of the length
  logic        len_over, len_over_next;     // set if length bits 23:19 are not all zero
  logic [18:0] expected_len, expected_len_next;
  logic [18:0] received_count, received_count_next;
  logic [15:0] chunk_count, chunk_count_next;
  logic [15:0] silence_ms, silence_ms_next;

  logic [16:0] silence_inc;
  logic [18:0] rc_inc;
  logic [15:0] cc_inc;
  logic        last_byte;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      phase          <= PH_START;
      len_seen       <= 2'd0;
      len_accum      <= 19'd0;
      len_over       <= 1'b0;
      expected_len   <= 19'd0;
      received_count <= 19'd0;
      chunk_count    <= 16'd0;
      silence_ms     <= 16'd0;
    end else if (fire) begin
      mode           <= mode_next;
      phase          <= phase_next;
      len_seen       <= len_seen_next;
      len_accum      <= len_accum_next;
      len_over       <= len_over_next;
      expected_len   <= expected_len_next;
      received_count <= received_count_next;
      chunk_count    <= chunk_count_next;
      silence_ms     <= silence_ms_next;
    end
  end

  assign silence_inc = {1'b0, silence_ms} + 17'd1;
  assign rc_inc      = received_count + 19'd1;
  assign cc_inc      = chunk_count + 16'd1;
  assign last_byte   = (rc_inc >= expected_len);

  // Next state and result
  always_comb begin
    mode_next           = mode;
    phase_next          = phase;
    len_seen_next       = len_seen;
    len_accum_next      = len_accum;
    len_over_next       = len_over;
    expected_len_next   = expected_len;
    received_count_next = received_count;
    chunk_count_next    = chunk_count;
    silence_ms_next     = silence_ms;

    res.status       = ST_NONE;
    res.write_offset = 18'd0;
    res.write_data   = 8'd0;
    res.tx_valid     = 1'b0;
    res.tx_byte      = 8'd0;

    unique case (op)
      OP_CAPTURE: begin
        if (mode == MODE_IDLE) begin
          mode_next           = MODE_WAIT;
          phase_next          = PH_START;
          len_seen_next       = 2'd0;
          len_accum_next      = 19'd0;
          len_over_next       = 1'b0;
          chunk_count_next    = 16'd0;
          silence_ms_next     = 16'd0;
          expected_len_next   = 19'd0;
          received_count_next = 19'd0;
          res.tx_valid        = 1'b1;
          res.tx_byte         = CH_CAPTURE;
        end
      end

      OP_RELEASE: begin
        if (mode == MODE_READY) begin
          mode_next           = MODE_IDLE;
          phase_next          = PH_START;
          len_seen_next       = 2'd0;
          len_accum_next      = 19'd0;
          len_over_next       = 1'b0;
          chunk_count_next    = 16'd0;
          silence_ms_next     = 16'd0;
          expected_len_next   = 19'd0;
          received_count_next = 19'd0;
        end
      end

      OP_TICK: begin
        // silence counts only once a frame has begun
        if (mode == MODE_WAIT && phase != PH_START) begin
          if (silence_inc > {1'b0, cfg.silence_timeout_ms}) begin
            mode_next           = MODE_IDLE;
            phase_next          = PH_START;
            len_seen_next       = 2'd0;
            len_accum_next      = 19'd0;
            len_over_next       = 1'b0;
            chunk_count_next    = 16'd0;
            silence_ms_next     = 16'd0;
            received_count_next = 19'd0;
            res.status          = ST_TIMEOUT;
          end else begin
            silence_ms_next = silence_inc[15:0];
          end
        end
      end

      OP_BYTE: begin
        if (mode == MODE_WAIT) begin
          silence_ms_next = 16'd0;
          unique case (phase)
            PH_START: begin
              if (rx_byte == CH_START) begin
                phase_next     = PH_SIZE;
                len_seen_next  = 2'd0;
                len_accum_next = 19'd0;
                len_over_next  = 1'b0;
              end else if (rx_byte == CH_ERROR) begin
                mode_next        = MODE_IDLE;
                phase_next       = PH_START;
                len_seen_next    = 2'd0;
                len_accum_next   = 19'd0;
                len_over_next    = 1'b0;
                chunk_count_next = 16'd0;
                res.status       = ST_CAM_ERR;
              end
            end

            PH_SIZE: begin
              // little-endian length, one byte per item
              unique case (len_seen)
                2'd0: begin
                  len_accum_next[7:0] = rx_byte;
                  len_seen_next       = 2'd1;
                end
                2'd1: begin
                  len_accum_next[15:8] = rx_byte;
                  len_seen_next        = 2'd2;
                end
                2'd2: begin
                  len_accum_next[18:16] = rx_byte[2:0];
                  len_over_next         = len_over | (rx_byte[7:3] != 5'd0);
                  len_seen_next         = 2'd3;
                end
                default: begin
                  len_seen_next = 2'd0;
                  if (len_over || (rx_byte != 8'd0) || (len_accum > MAX_IMAGE_BYTES)) begin
                    mode_next        = MODE_IDLE;
                    phase_next       = PH_START;
                    len_accum_next   = 19'd0;
                    len_over_next    = 1'b0;
                    chunk_count_next = 16'd0;
                    res.status       = ST_TOO_BIG;
                  end else begin
                    expected_len_next   = len_accum;
                    received_count_next = 19'd0;
                    chunk_count_next    = 16'd0;
                    phase_next          = (len_accum == 19'd0) ? PH_END : PH_DATA;
                  end
                end
              endcase
            end

            PH_DATA: begin
              res.status          = ST_DATA;
              res.write_offset    = received_count[17:0];
              res.write_data      = rx_byte;
              received_count_next = rc_inc;
              chunk_count_next    = cc_inc;
              if (cc_inc == cfg.ack_chunk_bytes || last_byte) begin
                res.tx_valid     = 1'b1;
                res.tx_byte      = CH_ACK;
                chunk_count_next = 16'd0;
              end
              if (last_byte) begin
                phase_next = PH_END;
              end
            end

            PH_END: begin
              if (rx_byte == CH_END) begin
                phase_next = PH_START;
                mode_next  = MODE_READY;
                res.status = ST_COMPLETE;
              end
            end
          endcase
        end
      end
    endcase

    res.image_size     = expected_len_next;
    res.bytes_received = received_count_next;
    res.camera_mode    = mode_next;
  end

endmodule

// ===== hdl/cifr_out.sv =====
// ----------------------------------------------------------------------------
// cifr_out
// Result register on the master side of the stream.
// ----------------------------------------------------------------------------
module cifr_out
  import cifr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  res_t  res,
  output logic  advance,
  output logic  m_tvalid,
  input  logic  m_tready,
  output res_t  res_q
);

  // register is free when empty or being drained this cycle
  assign advance = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

endmodule

// ===== hdl/camera_image_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// camera_image_frame_receiver_unit
// Datapath: an accepted item is loaded into the input register, then into the
//   result register once that register is free; the parser state updates
//   with the result register.
// Throughput: one item per cycle; s_tready drops only while the result
//   register is held by m_tready low and the input register is full.
// Reset: synchronous rst returns the parser to idle, clears both registers'
//   valid flags and loads the register defaults (15000 ms, 1024 bytes).
// ----------------------------------------------------------------------------
module camera_image_frame_receiver_unit
  import cifr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_tuser,   // [1:0] operation
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [17:0] write_offset, [25:18] write_data, [26] tx_valid, [34:27] tx_byte,
  // [53:35] image_size, [72:54] bytes_received, [74:73] camera_mode, rest 0
  output logic [79:0] m_tdata,
  output logic [2:0]  m_tuser,   // [2:0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  res_t       res, res_q;
  logic       in_valid;
  op_t        in_op;
  logic [7:0] in_byte;
  logic       advance;
  logic       fire;

  assign fire     = in_valid & advance;
  assign s_tready = ~in_valid | fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= op_t'(s_tuser);
      in_byte <= s_tdata;
    end
  end

  cifr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cifr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .op      (in_op),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .res     (res)
  );

  cifr_out u_out (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .res      (res),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res_q    (res_q)
  );

  // Pack the result item
  assign m_tuser = res_q.status;
  assign m_tdata = {5'd0,
                    res_q.camera_mode,
                    res_q.bytes_received,
                    res_q.image_size,
                    res_q.tx_byte,
                    res_q.tx_valid,
                    res_q.write_data,
                    res_q.write_offset};

endmodule

// ===== hdl/cifr_checker.sv =====
// ----------------------------------------------------------------------------
// cifr_checker
// Port-level checks on the result stream of the frame receiver.
// ----------------------------------------------------------------------------
module cifr_checker
  import cifr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // result stream is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result item changed");

  // a data byte leaves the block still waiting for the image
  a_data_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_DATA |-> m_tdata[74:73] == MODE_WAIT)
    else $error("data byte outside waiting mode");

  // completion puts the block in ready mode with all bytes counted
  a_complete: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_COMPLETE
      |-> m_tdata[74:73] == MODE_READY && m_tdata[72:54] == m_tdata[53:35])
    else $error("image complete with wrong mode or count");

  // timeout abandons the frame
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_TIMEOUT
      |-> m_tdata[74:73] == MODE_IDLE && m_tdata[72:54] == 19'd0)
    else $error("timeout left frame state behind");

endmodule

bind camera_image_frame_receiver_unit cifr_checker u_cifr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
